>>> rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants, codes and control structs of the byte deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

	// number of entries; must be a power of two
	localparam int DEPTH = 64;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_PUSH_BACK  = 3'd0,
		KIND_PUSH_FRONT = 3'd1,
		KIND_REMOVE     = 3'd2,
		KIND_CLEAR      = 3'd3,
		KIND_READ       = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic accept;
		logic walk;
		logic walk_finish;
		logic read_finish;
	} cmd_t;

	typedef struct packed {
		logic start_walk;
		logic start_read;
		logic walk_done;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/cdq_in_if.sv
// ----------------------------------------------------------------------------
// cdq_in_if
// Request channel: operation kind, byte value and read position.
// ----------------------------------------------------------------------------
interface cdq_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] value;
	logic [5:0] index;

	modport source (output valid, output kind, output value, output index, input ready);
	modport sink (input valid, input kind, input value, input index, output ready);
endinterface

>>> rtl/cdq_out_if.sv
// ----------------------------------------------------------------------------
// cdq_out_if
// Response channel: status, entry count and read byte.
// ----------------------------------------------------------------------------
interface cdq_out_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [cdq_pkg::CNT_W-1:0] count;
	logic [7:0]              read_data;

	modport source (output valid, output status, output count, output read_data, input ready);
	modport sink (input valid, input status, input count, input read_data, output ready);
endinterface

>>> rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller: accepts request beats and sequences reads and removal walks.
// ----------------------------------------------------------------------------
module cdq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cdq_pkg::stat_t stat,
	output cdq_pkg::cmd_t  cmd
);

	cdq_pkg::state_t state_q;
	cdq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cdq_pkg::ST_IDLE: begin
				if (req_valid && stat.out_free) begin
					if (stat.start_walk) begin
						state_d = cdq_pkg::ST_WALK;
					end else if (stat.start_read) begin
						state_d = cdq_pkg::ST_READ;
					end
				end
			end
			cdq_pkg::ST_READ: begin
				state_d = cdq_pkg::ST_IDLE;
			end
			cdq_pkg::ST_WALK: begin
				if (stat.walk_done) begin
					state_d = cdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cdq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready       = 1'b0;
		cmd             = '0;
		case (state_q)
			cdq_pkg::ST_IDLE: begin
				req_ready  = stat.out_free;
				cmd.accept = req_valid && stat.out_free;
			end
			cdq_pkg::ST_READ: begin
				cmd.read_finish = 1'b1;
			end
			cdq_pkg::ST_WALK: begin
				cmd.walk        = !stat.walk_done;
				cmd.walk_finish = stat.walk_done;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/cdq_dpath.sv
// ----------------------------------------------------------------------------
// cdq_dpath
// Datapath: circular entry memory, front and count registers, compaction
// walk and the response register.
// ----------------------------------------------------------------------------
module cdq_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       kind,
	input  logic [7:0]       value,
	input  logic [5:0]       index,
	input  cdq_pkg::cmd_t    cmd,
	output cdq_pkg::stat_t   stat,
	cdq_out_if.source        rsp
);

	localparam int PW = cdq_pkg::PTR_W;
	localparam int CW = cdq_pkg::CNT_W;

	logic [7:0]    mem_q [cdq_pkg::DEPTH];
	logic [7:0]    mem_rdata_q;
	logic          mem_we;
	logic          mem_re;
	logic [PW-1:0] mem_waddr;
	logic [PW-1:0] mem_raddr;
	logic [7:0]    mem_wdata;

	logic [PW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rd_pos_q, rd_pos_d;
	logic [CW-1:0] kept_q, kept_d;
	logic [7:0]    key_q, key_d;
	logic          rd_vld_q, rd_vld_d;

	logic             out_valid_q;
	cdq_pkg::status_t out_status_q, out_status;
	logic [CW-1:0]    out_count_q;
	logic [7:0]       out_data_q, out_data;
	logic             load_out;

	logic          full;
	logic [PW-1:0] front_m1;

	assign full     = (count_q == CW'(cdq_pkg::DEPTH));
	assign front_m1 = front_q - PW'(1);

	always_comb begin
		stat.start_walk = (kind == cdq_pkg::KIND_REMOVE) && (count_q != '0);
		stat.start_read = (kind == cdq_pkg::KIND_READ) && (CW'(index) < count_q);
		stat.walk_done  = (rd_pos_q == count_q) && !rd_vld_q;
		stat.out_free   = !out_valid_q || rsp.ready;
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem_q[mem_raddr];
		end
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_waddr  = front_q + count_q[PW-1:0];
		mem_raddr  = front_q + rd_pos_q[PW-1:0];
		mem_wdata  = value;
		front_d    = front_q;
		count_d    = count_q;
		rd_pos_d   = rd_pos_q;
		kept_d     = kept_q;
		key_d      = key_q;
		rd_vld_d   = 1'b0;
		load_out   = 1'b0;
		out_status = cdq_pkg::STATUS_OK;
		out_data   = 8'd0;

		if (cmd.accept) begin
			case (kind)
				cdq_pkg::KIND_PUSH_BACK: begin
					load_out = 1'b1;
					if (full) begin
						out_status = cdq_pkg::STATUS_FULL;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + CW'(1);
					end
				end
				cdq_pkg::KIND_PUSH_FRONT: begin
					load_out = 1'b1;
					if (full) begin
						out_status = cdq_pkg::STATUS_FULL;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = front_m1;
						front_d   = front_m1;
						count_d   = count_q + CW'(1);
					end
				end
				cdq_pkg::KIND_REMOVE: begin
					if (count_q == '0) begin
						front_d  = '0;
						load_out = 1'b1;
					end else begin
						key_d    = value;
						rd_pos_d = '0;
						kept_d   = '0;
					end
				end
				cdq_pkg::KIND_CLEAR: begin
					load_out = 1'b1;
					count_d  = '0;
					front_d  = '0;
				end
				cdq_pkg::KIND_READ: begin
					if (CW'(index) < count_q) begin
						mem_re    = 1'b1;
						mem_raddr = front_q + PW'(index);
					end else begin
						load_out   = 1'b1;
						out_status = cdq_pkg::STATUS_RANGE;
					end
				end
				default: begin
					load_out = 1'b1;
				end
			endcase
		end

		if (cmd.walk) begin
			if (rd_pos_q != count_q) begin
				mem_re   = 1'b1;
				rd_pos_d = rd_pos_q + CW'(1);
				rd_vld_d = 1'b1;
			end
			if (rd_vld_q && (mem_rdata_q != key_q)) begin
				mem_we    = 1'b1;
				mem_waddr = front_q + kept_q[PW-1:0];
				mem_wdata = mem_rdata_q;
				kept_d    = kept_q + CW'(1);
			end
		end

		if (cmd.walk_finish) begin
			load_out = 1'b1;
			count_d  = kept_q;
			if (kept_q == '0) begin
				front_d = '0;
			end
		end

		if (cmd.read_finish) begin
			load_out = 1'b1;
			out_data = mem_rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			front_q  <= front_d;
			count_q  <= count_d;
			rd_vld_q <= rd_vld_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_pos_q <= rd_pos_d;
		kept_q   <= kept_d;
		key_q    <= key_d;
		if (load_out) begin
			out_status_q <= out_status;
			out_count_q  <= count_d;
			out_data_q   <= out_data;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.count     = out_count_q;
	assign rsp.read_data = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(cdq_pkg::DEPTH))
		else $error("entry count above depth");

	a_kept_behind: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> (kept_q < rd_pos_q))
		else $error("compaction write overtook read");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || rsp.ready))
		else $error("response beat overwritten before taken");

	a_count_held_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |=> $stable(count_q))
		else $error("count changed during removal walk");

endmodule

>>> rtl/char_deque_remove_by_key.sv
// ----------------------------------------------------------------------------
// char_deque_remove_by_key
// Bounded byte deque with push at both ends, remove by key, clear and read.
// ----------------------------------------------------------------------------
// One request beat gives one response beat. Push, clear, an out-of-range read,
// a removal from an empty store and unused kinds answer in the cycle after
// acceptance; a valid read passes the registered read of the entry memory
// and then the response register. Remove by key walks the stored entries
// one per cycle through that memory's read and write ports, compacting in
// place, and answers once the walk is done. A new request is taken once the
// previous one has finished and the response register is empty or being
// emptied in the same cycle.
// ----------------------------------------------------------------------------
module char_deque_remove_by_key (
	input  logic      clk,
	input  logic      arst_n,
	cdq_in_if.sink    req,
	cdq_out_if.source rsp
);

	cdq_pkg::cmd_t  cmd;
	cdq_pkg::stat_t stat;
	logic           ready;

	assign req.ready = ready;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cdq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.kind   (req.kind),
		.value  (req.value),
		.index  (req.index),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
